[sv/phase_current_offset_calibrator_assert.svh]
// Assertion macros for the phase current offset calibrator.
// Included by the top level; no other dependencies.
`ifndef PHASE_CURRENT_OFFSET_CALIBRATOR_ASSERT_SVH
`define PHASE_CURRENT_OFFSET_CALIBRATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PCOC_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("calibrator check failed in %m");

// next-cycle implication, disabled in reset
`define PCOC_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("calibrator check failed in %m");

`endif

[sv/pcoc_pkg.sv]
// Shared widths, constants and types for the phase current offset calibrator.
// No dependencies.
package pcoc_pkg;

  localparam int NUM_PH   = 3;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 20;
  localparam int CNT_W    = 9;
  localparam int CUR_W    = 15;
  localparam int MAG_W    = CUR_W - 1;
  localparam int WIN_W    = 8;
  localparam int LIMIT_W  = 14;
  localparam int OSUM_W   = SAMPLE_W + 2;

  localparam int CAL_SAMPLES = 50;
  localparam int MUL_NUM     = 3128;
  localparam int MUL_DEN     = 1000;
  localparam int LIMIT_RESET = 6000;
  localparam int SAMPLE_MAX  = 2**SAMPLE_W - 1;

  // Constant divides done as multiply by a rounded-up reciprocal; each shift is
  // wide enough that the truncated quotient is exact over the operand range.
  localparam int OFF_SHIFT = SUM_W + 8;
  localparam longint unsigned OFF_RECIP =
    ((64'd1 << OFF_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int OFF_RECIP_W = $clog2(OFF_RECIP + 1);

  localparam int CUR_SHIFT = SAMPLE_W + 10;
  localparam longint unsigned CUR_RECIP =
    ((64'(MUL_NUM) << CUR_SHIFT) + MUL_DEN - 1) / MUL_DEN;
  localparam int CUR_RECIP_W = $clog2(CUR_RECIP + 1);

  localparam int MID_SHIFT = OSUM_W + 1;
  localparam longint unsigned MID_RECIP =
    ((64'd1 << MID_SHIFT) + NUM_PH - 1) / NUM_PH;
  localparam int MID_RECIP_W = $clog2(MID_RECIP + 1);

  localparam int SPAN_SHIFT = LIMIT_W + 12;
  localparam longint unsigned SPAN_RECIP =
    ((64'(MUL_DEN) << SPAN_SHIFT) + MUL_NUM - 1) / MUL_NUM;
  localparam int SPAN_RECIP_W = $clog2(SPAN_RECIP + 1);
  localparam int SPAN_W = $clog2(((2**LIMIT_W - 1) * MUL_DEN) / MUL_NUM + 1);
  localparam int SPAN_RESET = LIMIT_RESET * MUL_DEN / MUL_NUM;
  localparam int HI_W = ((SAMPLE_W > SPAN_W) ? SAMPLE_W : SPAN_W) + 1;

  localparam int S_TDATA_W = ((NUM_PH * SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((NUM_PH * CUR_W + 2 * WIN_W + 7) / 8) * 8;

  typedef enum logic {
    ACT_CAL  = 1'b0,
    ACT_MEAS = 1'b1
  } action_t;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t [NUM_PH-1:0] off;
    logic                 calibrated;
  } cal_state_t;

endpackage

[sv/pcoc_cal.sv]
// Calibration accumulator: per-phase sums, sample count, offsets and valid flag.
// Depends on pcoc_pkg.
module pcoc_cal import pcoc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  action_t              action,
  input  sample_t [NUM_PH-1:0] sample,
  output cal_state_t           cur,
  output cal_state_t           nxt
);

  localparam int QP_W = SUM_W + OFF_RECIP_W;

  logic [SUM_W-1:0] sum      [NUM_PH];
  logic [SUM_W-1:0] sum_next [NUM_PH];
  logic [QP_W-1:0]  quot_prod [NUM_PH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             done;
  cal_state_t       state;

  always_comb begin
    count_next = count + 1'b1;
    done       = (action == ACT_CAL) && (count_next >= CNT_W'(CAL_SAMPLES));
    nxt        = state;
    for (int i = 0; i < NUM_PH; i++) begin
      sum_next[i]  = sum[i] + SUM_W'(sample[i]);
      quot_prod[i] = QP_W'(sum_next[i]) * QP_W'(OFF_RECIP);
      if (done) begin
        nxt.off[i] = quot_prod[i][OFF_SHIFT +: SAMPLE_W];
      end
    end
    if (done) begin
      nxt.calibrated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      count <= '0;
      for (int i = 0; i < NUM_PH; i++) begin
        sum[i] <= '0;
      end
    end else if (step && action == ACT_CAL) begin
      state <= nxt;
      count <= done ? '0 : count_next;
      for (int i = 0; i < NUM_PH; i++) begin
        sum[i] <= done ? '0 : sum_next[i];
      end
    end
  end

  assign cur = state;

endmodule

[sv/phase_current_offset_calibrator.sv]
// Phase current offset calibrator, top level: stream ports, pipeline, window.
// Depends on pcoc_pkg, pcoc_cal and phase_current_offset_calibrator_assert.svh.
//
// Usage:
//   s_axis carries one triple of 12-bit phase samples per transaction; tuser
//   selects calibration (0) or measurement (1). Calibration transactions are
//   accumulated; every CAL_SAMPLES of them set new per-phase offsets.
//   m_axis returns exactly one result per input transaction, in order: three
//   signed currents in mA (zero for calibration), the offsets-valid flag in
//   tuser and the 8-bit overcurrent window.
//   cfg_we/cfg_wdata load the overcurrent limit; the window span is derived
//   in the write cycle. Write only while the pipeline is empty.
//   Pipeline: the input register loads at the accepting edge, then come the
//   multiply, offset-mean and output stages; result tvalid comes from the last.
//   Throughput: one transaction per cycle while m_axis does not stall, set by
//   the accumulator update in the first stage.
//   Reset clears sums, count, offsets, valid flag and all stage valids; the
//   limit returns to 6000 mA.
//   When m_axis stalls, stages fill one by one; s_axis_tready falls only once
//   all four stages hold a transaction.
`include "phase_current_offset_calibrator_assert.svh"

module phase_current_offset_calibrator import pcoc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [LIMIT_W-1:0]   cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [11:0] sample_a, [23:12] sample_b, [35:24] sample_c, rest zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] action
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [14:0] phase A mA, [29:15] phase B mA, [44:30] phase C mA,
  // [52:45] window_high, [60:53] window_low, rest zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] offsets_valid
  output logic                 m_axis_tuser
);

  localparam int CP_W = SAMPLE_W + CUR_RECIP_W;
  localparam int MP_W = OSUM_W + MID_RECIP_W;
  localparam int SP_W = LIMIT_W + SPAN_RECIP_W;

  // span register
  logic [SPAN_W-1:0] span;
  logic [SP_W-1:0]   span_prod;

  // stage 1: input register
  logic                 s1_valid;
  action_t              s1_action;
  sample_t [NUM_PH-1:0] s1_sample;

  // stage 2: current magnitudes and post-item calibration state
  logic                 s2_valid;
  logic [MAG_W-1:0]     s2_mag [NUM_PH];
  logic [NUM_PH-1:0]    s2_neg;
  cal_state_t           s2_st;

  // stage 3: signed currents and offset mean
  logic                 s3_valid;
  logic [CUR_W-1:0]     s3_cur [NUM_PH];
  sample_t              s3_mid;
  logic                 s3_cal;

  // output register
  logic                 out_valid;
  logic [CUR_W-1:0]     out_cur [NUM_PH];
  logic [WIN_W-1:0]     out_wh;
  logic [WIN_W-1:0]     out_wl;
  logic                 out_cal;

  logic out_ready, s3_ready, s2_ready, s1_ready, step;

  cal_state_t cal_cur, cal_nxt;

  // stage 1 logic
  logic [SAMPLE_W:0]   diff  [NUM_PH];
  logic [SAMPLE_W:0]   ndiff [NUM_PH];
  logic [SAMPLE_W-1:0] mag1  [NUM_PH];
  logic [CP_W-1:0]     cprod [NUM_PH];
  logic [MAG_W-1:0]    mag1q [NUM_PH];

  // stage 2 logic
  logic [OSUM_W-1:0]   osum;
  logic [MP_W-1:0]     mprod;
  logic [CUR_W-1:0]    cur2 [NUM_PH];

  // stage 3 logic
  logic [HI_W-1:0]     hi, lo;
  sample_t             hi_c, lo_c;
  logic [WIN_W-1:0]    wh3, wl3;

  assign out_ready     = !out_valid || m_axis_tready;
  assign s3_ready      = !s3_valid || out_ready;
  assign s2_ready      = !s2_valid || s3_ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign s_axis_tready = s1_ready;
  assign step          = s1_valid && s2_ready;

  pcoc_cal u_cal (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .action (s1_action),
    .sample (s1_sample),
    .cur    (cal_cur),
    .nxt    (cal_nxt)
  );

  // limit to span: limit * MUL_DEN / MUL_NUM
  assign span_prod = SP_W'(cfg_wdata) * SP_W'(SPAN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_W'(SPAN_RESET);
    end else if (cfg_we) begin
      span <= span_prod[SPAN_SHIFT +: SPAN_W];
    end
  end

  // |sample - offset| * MUL_NUM / MUL_DEN, using pre-item offsets; zero for calibration
  always_comb begin
    for (int i = 0; i < NUM_PH; i++) begin
      diff[i]  = {1'b0, s1_sample[i]} - {1'b0, cal_cur.off[i]};
      ndiff[i] = ~diff[i] + 1'b1;
      mag1[i]  = diff[i][SAMPLE_W] ? ndiff[i][SAMPLE_W-1:0] : diff[i][SAMPLE_W-1:0];
      cprod[i] = CP_W'(mag1[i]) * CP_W'(CUR_RECIP);
      mag1q[i] = (s1_action == ACT_MEAS) ? cprod[i][CUR_SHIFT +: MAG_W] : '0;
    end
  end

  always_comb begin
    osum  = OSUM_W'(s2_st.off[0]) + OSUM_W'(s2_st.off[1]) + OSUM_W'(s2_st.off[2]);
    mprod = MP_W'(osum) * MP_W'(MID_RECIP);
    for (int i = 0; i < NUM_PH; i++) begin
      cur2[i] = s2_neg[i] ? (~{1'b0, s2_mag[i]} + 1'b1) : {1'b0, s2_mag[i]};
    end
  end

  // window around offset mean, clamped to the ADC range; zero until offsets are valid
  always_comb begin
    hi   = HI_W'(s3_mid) + HI_W'(span);
    lo   = HI_W'(s3_mid) - HI_W'(span);
    hi_c = (hi > HI_W'(SAMPLE_MAX)) ? sample_t'(SAMPLE_MAX) : hi[SAMPLE_W-1:0];
    lo_c = (HI_W'(s3_mid) > HI_W'(span)) ? lo[SAMPLE_W-1:0] : '0;
    wh3  = s3_cal ? hi_c[SAMPLE_W-1 -: WIN_W] : '0;
    wl3  = s3_cal ? lo_c[SAMPLE_W-1 -: WIN_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_action <= action_t'(s_axis_tuser);
      for (int i = 0; i < NUM_PH; i++) begin
        s1_sample[i] <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
      end
    end
    if (s2_ready) begin
      s2_st <= cal_nxt;
      for (int i = 0; i < NUM_PH; i++) begin
        s2_mag[i] <= mag1q[i];
        s2_neg[i] <= diff[i][SAMPLE_W];
      end
    end
    if (s3_ready) begin
      s3_mid <= mprod[MID_SHIFT +: SAMPLE_W];
      s3_cal <= s2_st.calibrated;
      for (int i = 0; i < NUM_PH; i++) begin
        s3_cur[i] <= cur2[i];
      end
    end
    if (out_ready) begin
      out_wh  <= wh3;
      out_wl  <= wl3;
      out_cal <= s3_cal;
      for (int i = 0; i < NUM_PH; i++) begin
        out_cur[i] <= s3_cur[i];
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_cal;
  assign m_axis_tdata  = M_TDATA_W'({out_wl, out_wh, out_cur[2], out_cur[1], out_cur[0]});

  `PCOC_ASSERT_IMP(a_win_zero_uncal, clk, rst, out_valid && !out_cal, out_wh == '0 && out_wl == '0)
  `PCOC_ASSERT_IMP(a_win_ordered, clk, rst, out_valid, out_wl <= out_wh)
  `PCOC_ASSERT_NXT(a_cal_sticky, clk, rst, cal_cur.calibrated, cal_cur.calibrated)
  `PCOC_ASSERT_NXT(a_accept_loads, clk, rst, s_axis_tvalid && s_axis_tready, s1_valid)

endmodule

[dv/phase_current_offset_calibrator_tb.sv]
// Self-checking testbench for phase_current_offset_calibrator: random stream traffic,
// limit changes between phases, results checked against an in-bench calibration model.
// Depends on pcoc_pkg and the calibrator RTL only.
`timescale 1ns / 1ps

module phase_current_offset_calibrator_tb import pcoc_pkg::*; ;

  localparam int ITEM_TARGET     = 1300;
  localparam int NUM_PHASES      = 6;
  localparam int PIPE_LATENCY    = 6;
  localparam int STALL_LIMIT     = 2000;
  localparam int RX_HOLD_CYCLES  = 80;
  localparam int IDLE_PCT        = 35;
  localparam int LIMIT_MAX_RATED = 12800;
  localparam int REPORT_MAX      = 10;

  typedef struct packed {
    logic [NUM_PH-1:0][CUR_W-1:0] cur;
    logic [WIN_W-1:0]             win_hi;
    logic [WIN_W-1:0]             win_lo;
    logic                         offsets_ok;
  } reading_t;

  // Tracks the calibration state and the readings still owed by the block.
  class calib_scoreboard;
    logic [SUM_W-1:0]   acc [NUM_PH];
    int unsigned        cal_seen;
    sample_t            offset [NUM_PH];
    bit                 have_offsets;
    logic [LIMIT_W-1:0] limit_ma;
    reading_t           expected_readings [$];
    int unsigned        mismatches;

    function new();
      for (int p = 0; p < NUM_PH; p++) begin
        acc[p] = '0;
        offset[p] = '0;
      end
      cal_seen = 0;
      have_offsets = 1'b0;
      limit_ma = LIMIT_W'(LIMIT_RESET);
      mismatches = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit_ma = v;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // (sample - offset) * 3128 / 1000, truncated toward zero
    function logic [CUR_W-1:0] to_milliamps(sample_t s, sample_t off);
      int ma;
      ma = (int'(s) - int'(off)) * MUL_NUM / MUL_DEN;
      return ma[CUR_W-1:0];
    endfunction

    function void note_sample(action_t act, sample_t a, sample_t b, sample_t c);
      sample_t     smp [NUM_PH];
      reading_t    r;
      int unsigned span, mid, hi, lo;
      smp[0] = a;
      smp[1] = b;
      smp[2] = c;
      r = '0;
      if (act == ACT_CAL) begin
        for (int p = 0; p < NUM_PH; p++) acc[p] = acc[p] + SUM_W'(smp[p]);
        cal_seen++;
        if (cal_seen >= CAL_SAMPLES) begin
          for (int p = 0; p < NUM_PH; p++) begin
            offset[p] = sample_t'(acc[p] / CAL_SAMPLES);
            acc[p] = '0;
          end
          have_offsets = 1'b1;
          cal_seen = 0;
        end
      end else begin
        for (int p = 0; p < NUM_PH; p++) r.cur[p] = to_milliamps(smp[p], offset[p]);
      end
      if (have_offsets) begin
        span = int'(limit_ma) * MUL_DEN / MUL_NUM;
        mid = (int'(offset[0]) + int'(offset[1]) + int'(offset[2])) / NUM_PH;
        hi = mid + span;
        lo = (mid > span) ? mid - span : 0;
        if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
        r.win_hi = WIN_W'(hi >> 4);
        r.win_lo = WIN_W'(lo >> 4);
      end
      r.offsets_ok = have_offsets;
      expected_readings.push_back(r);
    endfunction

    function void check_output(logic [M_TDATA_W-1:0] data, logic flag);
      reading_t got, want;
      for (int p = 0; p < NUM_PH; p++) got.cur[p] = data[p*CUR_W +: CUR_W];
      got.win_hi = data[NUM_PH*CUR_W +: WIN_W];
      got.win_lo = data[NUM_PH*CUR_W + WIN_W +: WIN_W];
      got.offsets_ok = flag;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with no reading pending: tdata=%h tuser=%b", $realtime,
                   data, flag);
        return;
      end
      want = expected_readings.pop_front();
      if (got.cur[0] !== want.cur[0] || got.cur[1] !== want.cur[1] ||
          got.cur[2] !== want.cur[2] || got.win_hi !== want.win_hi ||
          got.win_lo !== want.win_lo || got.offsets_ok !== want.offsets_ok) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: reading mismatch", $realtime);
          $display("  exp: I=%0d/%0d/%0d valid=%b win=%0d..%0d",
                   $signed(want.cur[0]), $signed(want.cur[1]), $signed(want.cur[2]),
                   want.offsets_ok, want.win_lo, want.win_hi);
          $display("  got: I=%0d/%0d/%0d valid=%b win=%0d..%0d",
                   $signed(got.cur[0]), $signed(got.cur[1]), $signed(got.cur[2]),
                   got.offsets_ok, got.win_lo, got.win_hi);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [LIMIT_W-1:0]   cfg_wdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  calib_scoreboard sb;
  int              items_sent;
  int              cal_in_round;
  int              stall_cycles;
  bit              no_idle;
  bit              rx_hold_req;
  sample_t         round_base [NUM_PH];

  phase_current_offset_calibrator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transaction monitor: both sides sampled at the edge, before any drive update
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(action_t'(s_axis_tuser), s_axis_tdata[0 +: SAMPLE_W],
                       s_axis_tdata[SAMPLE_W +: SAMPLE_W],
                       s_axis_tdata[2*SAMPLE_W +: SAMPLE_W]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_output(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result sink: random backpressure, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_item(input action_t act, input sample_t a, b, c);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(S_TDATA_W - NUM_PH*SAMPLE_W){1'b0}}, c, b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (act == ACT_CAL) cal_in_round = (cal_in_round + 1) % CAL_SAMPLES;
  endtask

  function automatic sample_t jitter_sample(sample_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(2*spread)) - spread;
    if (v < 0) v = 0;
    else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return sample_t'(v);
  endfunction

  function automatic sample_t measure_sample(sample_t base);
    case ($urandom_range(3))
      0: return sample_t'($urandom_range(SAMPLE_MAX));
      1: return $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(0);
      default: return jitter_sample(base, 600);
    endcase
  endfunction

  task automatic send_measure();
    sample_t s [NUM_PH];
    for (int p = 0; p < NUM_PH; p++) s[p] = measure_sample(round_base[p]);
    send_item(ACT_MEAS, s[0], s[1], s[2]);
  endtask

  // One calibration round with measurements mixed in; some rounds are cut short
  // and finished by a later one, which draws its own profile.
  task automatic run_episode();
    int      profile;
    int      to_send;
    sample_t s [NUM_PH];
    profile = $urandom_range(9);
    for (int p = 0; p < NUM_PH; p++)
      round_base[p] = (profile == 0) ? sample_t'(SAMPLE_MAX) :
                      (profile == 1) ? sample_t'(0) : sample_t'($urandom_range(SAMPLE_MAX));
    to_send = CAL_SAMPLES - cal_in_round;
    if ($urandom_range(4) == 0) to_send = $urandom_range(1, to_send);
    while (to_send > 0) begin
      if ($urandom_range(4) == 0) begin
        send_measure();
      end else begin
        for (int p = 0; p < NUM_PH; p++)
          s[p] = (profile < 2) ? round_base[p] :
                 (profile < 4) ? sample_t'($urandom_range(SAMPLE_MAX)) :
                 jitter_sample(round_base[p], 40);
        send_item(ACT_CAL, s[0], s[1], s[2]);
        to_send--;
      end
    end
    repeat ($urandom_range(2, 15)) send_measure();
  endtask

  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  initial begin
    logic [LIMIT_W-1:0] lim;
    sb = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_CAL;
    items_sent    = 0;
    cal_in_round  = 0;
    stall_cycles  = 0;
    no_idle       = 1'b0;
    rx_hold_req   = 1'b0;
    for (int p = 0; p < NUM_PH; p++) round_base[p] = sample_t'(SAMPLE_MAX / 2);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // measurements on reset offsets, window still zero
    send_item(ACT_MEAS, '0, '0, '0);
    send_item(ACT_MEAS, sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
    send_item(ACT_MEAS, sample_t'(SAMPLE_MAX), '0, sample_t'(2048));
    // partial round, then measurements mid-round
    send_item(ACT_CAL, sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
    send_item(ACT_CAL, '0, '0, '0);
    send_item(ACT_CAL, sample_t'(1234), sample_t'(2345), sample_t'(3456));
    send_item(ACT_MEAS, sample_t'(2048), sample_t'(1), sample_t'(SAMPLE_MAX - 1));
    send_item(ACT_MEAS, sample_t'(12'hAAA), sample_t'(12'h555), sample_t'(12'hF0F));
    send_item(ACT_CAL, sample_t'(12'h555), sample_t'(12'hAAA), sample_t'(12'h0F0));
    send_item(ACT_MEAS, '0, sample_t'(SAMPLE_MAX), '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_block();
        case (ph)
          1: lim = '0;
          2: lim = '1;
          3: lim = LIMIT_W'(LIMIT_MAX_RATED);
          4: lim = LIMIT_W'($urandom_range(2**LIMIT_W - 1));
          default: lim = LIMIT_W'($urandom_range(LIMIT_MAX_RATED));
        endcase
        write_limit(lim);
      end
      no_idle = (ph == 2);
      // sink stalls while we keep offering: pipeline fills and input backs up
      if (ph == 3 || ph == 5) rx_hold_req = 1'b1;
      while (items_sent < (ph + 1) * ITEM_TARGET / NUM_PHASES) run_episode();
    end

    drain_block();
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[phase_current_offset_calibrator.f]
+incdir+sv
sv/pcoc_pkg.sv
sv/pcoc_cal.sv
sv/phase_current_offset_calibrator.sv
dv/phase_current_offset_calibrator_tb.sv
